FILE: sv/rssg_pkg.sv
`timescale 1ns / 1ps
package rssg_pkg;

    localparam int SCREEN_W_BITS = 10;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SCREEN_W_BITS-1:0] RESET_SCREEN_WIDTH  = 10'd320;
    localparam logic [SCREEN_W_BITS-1:0] RESET_SCREEN_HEIGHT = 10'd240;

    localparam int RADICAND_BITS = 20;
    localparam int ROOT_BITS     = 10;

    localparam int S_TDATA_BITS = 88;
    localparam int M_TDATA_BITS = 48;

    localparam logic FUNC_CIRCLE = 1'b0;
    localparam logic FUNC_RRECT  = 1'b1;

endpackage

FILE: sv/rssg_sqrt.sv
`timescale 1ns / 1ps
module rssg_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rssg_pkg::RADICAND_BITS-1:0]  i_radicand,
    output logic                                o_done,
    output logic [rssg_pkg::ROOT_BITS-1:0]      o_root
);

    localparam int RB = rssg_pkg::RADICAND_BITS;

    logic [RB-1:0] r_rem,  n_rem;
    logic [RB-1:0] r_root, n_root;
    logic [RB-1:0] r_bit,  n_bit;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [RB:0]   trial;

    always_comb begin
        trial  = {1'b0, r_root} + {1'b0, r_bit};
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_radicand;
            n_root = '0;
            n_bit  = {2'b01, {(RB-2){1'b0}}};
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                n_rem  = r_rem - trial[RB-1:0];
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[rssg_pkg::ROOT_BITS-1:0];

endmodule

FILE: sv/round_shape_span_generator_core.sv
`timescale 1ns / 1ps
// Round shape span generator: one clipped horizontal span per input word.
// Input word (s_axis): a request for one row of a filled circle (tuser = 0)
// or rounded rectangle (tuser = 1). Output word (m_axis): one result per
// request, tuser = visible flag, tdata = row, start column, length, color.
// When visible is low the row, start and length fields are zero.
// Clip screen size (write port: index 0 width, index 1 height) must be set by
// the user only while the block is idle; the block itself does not enforce it.
// Steps from input acceptance to output valid: setup, two squaring steps
// on one shared 10x10 multiplier, 10 iterations of the digit-by-digit
// square root unit, span build and clip. The square-root loop is the
// longest step. One request is in work at a time, so a new word is
// accepted only once the previous result has left the clip step.
// The result sits in an output register; s_axis_tready comes back while it
// waits, but a second finished result stalls until m_axis_tready takes the
// first one.
// Reset (synchronous, active low) drops the output valid flag, returns to idle
// and restores the screen size to 320 x 240.
module round_shape_span_generator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x[11:0], pos_y[23:12], shape_width[34:24], shape_height[45:35],
    // radius[56:46], row_index[67:57], pixel_color[83:68], zero pad
    input  logic [rssg_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // func[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // span_row[9:0], span_start[19:10], span_length[29:20], span_color[45:30],
    // zero pad
    output logic [rssg_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
    // visible[0]
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [rssg_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [rssg_pkg::SCREEN_W_BITS-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SQA  = 3'd2;
    localparam logic [2:0] S_SQB  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_SPAN = 3'd5;
    localparam logic [2:0] S_CLIP = 3'd6;

    logic [2:0] r_state, n_state;

    logic [9:0] r_scr_w, r_scr_h;

    logic               r_func;
    logic signed [11:0] r_px, r_py;
    logic signed [10:0] r_w, r_h, r_r;
    logic [10:0]        r_k;
    logic [15:0]        r_color;

    logic               r_ok;
    logic [9:0]         r_a, r_dy;
    logic signed [13:0] r_sy, r_sx, r_e, r_len;
    logic [19:0]        r_prod;

    logic        r_ovalid;
    logic        r_ovis;
    logic [9:0]  r_orow, r_ostart, r_olen;
    logic [15:0] r_ocolor;

    logic s_acc;
    logic out_free;

    logic signed [13:0] px14, py14, w14, h14, r14, k14;
    logic signed [13:0] dyc, dyc_abs, wh, hh, mwh, mr, rc, hm, dyr;
    logic               ok_c, ok_r;

    logic [9:0]  m_op;
    logic [19:0] m_sq;

    logic        sq_start, sq_done;
    logic [19:0] sq_rad;
    logic [9:0]  sq_root;

    logic signed [13:0] s14, inset;
    logic signed [13:0] w_ext, h_ext, st, en, ln;
    logic               vis;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    // row setup
    always_comb begin
        px14    = {{2{r_px[11]}}, r_px};
        py14    = {{2{r_py[11]}}, r_py};
        w14     = {{3{r_w[10]}}, r_w};
        h14     = {{3{r_h[10]}}, r_h};
        r14     = {{3{r_r[10]}}, r_r};
        k14     = {3'b000, r_k};
        ok_c    = (r14 > 14'sd0) && (k14 <= (r14 <<< 1));
        dyc     = k14 - r14;
        dyc_abs = (dyc < 14'sd0) ? -dyc : dyc;
        ok_r    = (w14 > 14'sd0) && (h14 > 14'sd0) && (k14 < h14);
        wh      = w14 >>> 1;
        hh      = h14 >>> 1;
        mwh     = (wh < hh) ? wh : hh;
        mr      = (r14 < mwh) ? r14 : mwh;
        rc      = (mr < 14'sd0) ? 14'sd0 : mr;
        hm      = h14 - rc;
        if (rc > 14'sd0 && k14 < rc) begin
            dyr = rc - k14;
        end else if (rc > 14'sd0 && k14 >= hm) begin
            dyr = k14 - hm + 14'sd1;
        end else begin
            dyr = 14'sd0;
        end
    end

    // shared squarer
    assign m_op     = (r_state == S_SQA) ? r_a : r_dy;
    assign m_sq     = {10'd0, m_op} * {10'd0, m_op};
    assign sq_start = (r_state == S_SQB);
    assign sq_rad   = r_prod - m_sq;

    rssg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // span build and clip
    always_comb begin
        s14   = {4'b0000, sq_root};
        inset = {4'b0000, r_a} - s14;
        w_ext = {4'b0000, r_scr_w};
        h_ext = {4'b0000, r_scr_h};
        st    = (r_sx < 14'sd0) ? 14'sd0 : r_sx;
        en    = (r_e > w_ext) ? w_ext : r_e;
        ln    = en - st;
        vis   = r_ok && (r_len > 14'sd0) && (r_sy >= 14'sd0) && (r_sy < h_ext)
                && (r_sx < w_ext) && (r_e > 14'sd0) && (ln > 14'sd0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = S_PREP;
            S_PREP: n_state = S_SQA;
            S_SQA:  n_state = S_SQB;
            S_SQB:  n_state = S_ROOT;
            S_ROOT: if (sq_done) n_state = S_SPAN;
            S_SPAN: n_state = S_CLIP;
            S_CLIP: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scr_w  <= rssg_pkg::RESET_SCREEN_WIDTH;
            r_scr_h  <= rssg_pkg::RESET_SCREEN_HEIGHT;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLIP && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_addr == rssg_pkg::CFG_SCREEN_WIDTH) begin
                r_scr_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_addr == rssg_pkg::CFG_SCREEN_HEIGHT) begin
                r_scr_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_func  <= s_axis_tuser;
            r_px    <= s_axis_tdata[11:0];
            r_py    <= s_axis_tdata[23:12];
            r_w     <= s_axis_tdata[34:24];
            r_h     <= s_axis_tdata[45:35];
            r_r     <= s_axis_tdata[56:46];
            r_k     <= s_axis_tdata[67:57];
            r_color <= s_axis_tdata[83:68];
        end
        if (r_state == S_PREP) begin
            if (r_func == rssg_pkg::FUNC_RRECT) begin
                r_ok <= ok_r;
                r_a  <= rc[9:0];
                r_dy <= dyr[9:0];
                r_sy <= py14 + k14;
            end else begin
                r_ok <= ok_c;
                r_a  <= r14[9:0];
                r_dy <= dyc_abs[9:0];
                r_sy <= py14 + k14 - r14;
            end
        end
        if (r_state == S_SQA) begin
            r_prod <= m_sq;
        end
        if (r_state == S_SPAN) begin
            if (r_func == rssg_pkg::FUNC_RRECT) begin
                r_sx  <= px14 + inset;
                r_e   <= px14 + w14 - inset;
                r_len <= w14 - (inset <<< 1);
            end else begin
                r_sx  <= px14 - s14;
                r_e   <= px14 + s14 + 14'sd1;
                r_len <= (s14 <<< 1) + 14'sd1;
            end
        end
        if (r_state == S_CLIP && out_free) begin
            r_ovis   <= vis;
            r_orow   <= vis ? r_sy[9:0] : 10'd0;
            r_ostart <= vis ? st[9:0] : 10'd0;
            r_olen   <= vis ? ln[9:0] : 10'd0;
            r_ocolor <= r_color;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ovis;
    assign m_axis_tdata  = {2'b00, r_ocolor, r_olen, r_ostart, r_orow};

endmodule
